### rtl/hcbp_pkg.sv
// Package for the Huffman code bit packer: field widths, table geometry,
// item modes and sequencer states. It depends on nothing else.
`default_nettype none
package hcbp_pkg;

  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int TBL_DEPTH    = 256;
  localparam int ENTRY_W      = CODE_W + LEN_W;
  localparam int PEND_W       = 7;
  localparam int CNT_W        = 3;
  localparam int ACC_W        = PEND_W + CODE_W;
  localparam int BYTE_W       = 8;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_EMIT  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### rtl/hcbp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// It depends on no other file.
`default_nettype none
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/huffman_code_bit_packer_top.sv
// Top level of the Huffman code bit packer: code table RAM, bit accumulator,
// byte emit sequencer and output register. Uses hcbp_pkg and hcbp_ram.
//
// The block takes one request at a time. A load writes the 256-entry code
// table RAM. An encode reads the table RAM, merges the code with the pending
// bits, emits each full byte (up to four) through the single output register,
// holding while that register is stalled, and then stores the leftover bits.
// A flush emits a padded byte only when bits are pending. Unwritten table
// entries read as undefined data.
`default_nettype none
module huffman_code_bit_packer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [hcbp_pkg::SYM_W-1:0]    in_symbol,
  input  wire logic [hcbp_pkg::CODE_W-1:0]   in_code_bits,
  input  wire logic [hcbp_pkg::LEN_W-1:0]    in_code_length,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]        out_packed_byte,
  output logic                               out_last_of_run,
  output logic                               out_padded_final
);

  hcbp_pkg::state_t state_r, state_nxt;

  logic [hcbp_pkg::PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [hcbp_pkg::CNT_W-1:0]  pend_cnt_r, pend_cnt_nxt;
  logic [hcbp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hcbp_pkg::LEN_W-1:0]  total_r, total_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [hcbp_pkg::BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_pad_r, out_pad_nxt;

  logic                         accept;
  logic                         slot_free;
  logic                         tbl_wr;
  logic [hcbp_pkg::LEN_W-1:0]   load_len;
  logic [hcbp_pkg::CODE_W:0]    load_mask;
  logic [hcbp_pkg::ENTRY_W-1:0] tbl_wdata;
  logic [hcbp_pkg::ENTRY_W-1:0] tbl_rdata;
  logic [hcbp_pkg::LEN_W-1:0]   rd_len;
  logic [hcbp_pkg::CODE_W-1:0]  rd_code;
  logic [hcbp_pkg::LEN_W-1:0]   shift_amt;
  logic [hcbp_pkg::ACC_W-1:0]   acc_shifted;
  logic [hcbp_pkg::BYTE_W-1:0]  pend_mask;

  assign in_stall  = (state_r != hcbp_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Loads clamp the length and drop code bits above it before the write.
  always_comb begin
    if (in_code_length > hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP)) begin
      load_len = hcbp_pkg::LEN_W'(hcbp_pkg::LEN_CAP);
    end else begin
      load_len = in_code_length;
    end
  end
  assign load_mask = ((hcbp_pkg::CODE_W + 1)'(1) << load_len) - (hcbp_pkg::CODE_W + 1)'(1);
  assign tbl_wdata = {load_len, in_code_bits & load_mask[hcbp_pkg::CODE_W-1:0]};
  assign tbl_wr    = accept && (in_mode == hcbp_pkg::MODE_LOAD);

  hcbp_ram #(
    .WIDTH (hcbp_pkg::ENTRY_W),
    .DEPTH (hcbp_pkg::TBL_DEPTH)
  ) u_code_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (in_symbol),
    .wr_data (tbl_wdata),
    .rd_addr (in_symbol),
    .rd_data (tbl_rdata)
  );

  assign rd_len  = tbl_rdata[hcbp_pkg::ENTRY_W-1:hcbp_pkg::CODE_W];
  assign rd_code = tbl_rdata[hcbp_pkg::CODE_W-1:0];

  // The next byte to emit sits just above the bits that remain after it.
  assign shift_amt   = total_r - hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W);
  assign acc_shifted = acc_r >> shift_amt;
  assign pend_mask   = (hcbp_pkg::BYTE_W'(1) << total_r[hcbp_pkg::CNT_W-1:0])
                       - hcbp_pkg::BYTE_W'(1);

  always_comb begin
    state_nxt     = state_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_pad_nxt   = out_pad_r;

    case (state_r)
      hcbp_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            hcbp_pkg::MODE_ENCODE: state_nxt = hcbp_pkg::ST_READ;
            hcbp_pkg::MODE_FLUSH: begin
              if (pend_cnt_r != '0) begin
                state_nxt = hcbp_pkg::ST_FLUSH;
              end
            end
            default: state_nxt = hcbp_pkg::ST_IDLE;
          endcase
        end
      end
      hcbp_pkg::ST_READ: begin
        acc_nxt   = ({{hcbp_pkg::CODE_W{1'b0}}, pend_bits_r} << rd_len)
                    | {{hcbp_pkg::PEND_W{1'b0}}, rd_code};
        total_nxt = {{(hcbp_pkg::LEN_W - hcbp_pkg::CNT_W){1'b0}}, pend_cnt_r} + rd_len;
        state_nxt = hcbp_pkg::ST_EMIT;
      end
      hcbp_pkg::ST_EMIT: begin
        if (total_r >= hcbp_pkg::LEN_W'(hcbp_pkg::BYTE_W)) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = acc_shifted[hcbp_pkg::BYTE_W-1:0];
            out_last_nxt  = (total_r < hcbp_pkg::LEN_W'(2 * hcbp_pkg::BYTE_W));
            out_pad_nxt   = 1'b0;
            total_nxt     = shift_amt;
          end
        end else begin
          pend_bits_nxt = acc_r[hcbp_pkg::PEND_W-1:0] & pend_mask[hcbp_pkg::PEND_W-1:0];
          pend_cnt_nxt  = total_r[hcbp_pkg::CNT_W-1:0];
          state_nxt     = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = {1'b0, pend_bits_r}
                          << (hcbp_pkg::CNT_W + 1)'(hcbp_pkg::BYTE_W - 32'(pend_cnt_r));
          out_last_nxt  = 1'b1;
          out_pad_nxt   = 1'b1;
          pend_bits_nxt = '0;
          pend_cnt_nxt  = '0;
          state_nxt     = hcbp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hcbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcbp_pkg::ST_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    total_r    <= total_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_pad_r  <= out_pad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_packed_byte  = out_byte_r;
  assign out_last_of_run  = out_last_r;
  assign out_padded_final = out_pad_r;

endmodule
`default_nettype wire

### test/tb.sv
// Self-checking testbench for huffman_code_bit_packer_top: a byte scoreboard predicts the packed
// output of every accepted request and checks each output byte in order.
// Depends on hcbp_pkg and the RTL of the block only.
`default_nettype none
module tb;
  import hcbp_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 12;
  localparam int RAND_ITEMS  = 76;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              pad;
  } packed_byte_t;

  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_style_t;

  // Scoreboard: keeps its own copy of the code table and the bit accumulator.
  class byte_scoreboard;
    logic [CODE_W-1:0] code_word [TBL_DEPTH];
    logic [LEN_W-1:0]  code_len  [TBL_DEPTH];
    logic [PEND_W-1:0] acc_bits;
    logic [CNT_W-1:0]  acc_count;
    packed_byte_t      expected_bytes [$];
    int                errors;

    function new();
      acc_bits  = '0;
      acc_count = '0;
      errors    = 0;
      foreach (code_len[i]) begin
        code_len[i]  = '0;
        code_word[i] = '0;
      end
    endfunction

    function void report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endfunction

    function void note_request(logic [1:0] mode, logic [SYM_W-1:0] sym,
                               logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
      logic [ACC_W-1:0] acc;
      logic [63:0]      mask;
      packed_byte_t     pb;
      int               clen;
      int               total;
      int               nbytes;
      case (mode_t'(mode))
        MODE_LOAD: begin
          if (len > LEN_CAP) len = LEN_W'(LEN_CAP);
          mask = (64'd1 << len) - 64'd1;
          code_len[sym]  = len;
          code_word[sym] = code & mask[CODE_W-1:0];
        end
        MODE_ENCODE: begin
          clen   = int'(code_len[sym]);
          acc    = (ACC_W'(acc_bits) << clen) | ACC_W'(code_word[sym]);
          total  = int'(acc_count) + clen;
          nbytes = total / BYTE_W;
          for (int k = 0; k < nbytes; k++) begin
            total   -= BYTE_W;
            pb.data = BYTE_W'(acc >> total);
            pb.last = (k == nbytes - 1);
            pb.pad  = 1'b0;
            expected_bytes.push_back(pb);
          end
          mask      = (64'd1 << total) - 64'd1;
          acc_bits  = PEND_W'(acc & mask[ACC_W-1:0]);
          acc_count = CNT_W'(total);
        end
        MODE_FLUSH: begin
          if (acc_count != 0) begin
            pb.data = {1'b0, acc_bits} << (BYTE_W - int'(acc_count));
            pb.last = 1'b1;
            pb.pad  = 1'b1;
            expected_bytes.push_back(pb);
          end
          acc_bits  = '0;
          acc_count = '0;
        end
        default: begin
          // The unused mode leaves everything untouched.
        end
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last, logic pad);
      packed_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %h last=%b pad=%b", data, last, pad));
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (data !== exp_b.data || last !== exp_b.last || pad !== exp_b.pad)
        report($sformatf("byte %h last=%b pad=%b, expected %h last=%b pad=%b",
                         data, last, pad, exp_b.data, exp_b.last, exp_b.pad));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_mode;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code_bits;
  logic [LEN_W-1:0]  in_code_length;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_packed_byte;
  logic              out_last_of_run;
  logic              out_padded_final;

  byte_scoreboard    sb = new();
  int                burst_left = 0;
  int                idle_cycles = 0;
  int                stall_left = 0;
  rx_style_t         rx_style = RX_OPEN;
  bit                written [TBL_DEPTH];
  logic [SYM_W-1:0]  loaded_syms [$];

  huffman_code_bit_packer_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_symbol        (in_symbol),
    .in_code_bits     (in_code_bits),
    .in_code_length   (in_code_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_packed_byte  (out_packed_byte),
    .out_last_of_run  (out_last_of_run),
    .out_padded_final (out_padded_final)
  );

  always #2 clk = ~clk;

  // Both channels are sampled here with their pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request(in_mode, in_symbol, in_code_bits, in_code_length);
      if (out_valid && !out_stall)
        sb.check_byte(out_packed_byte, out_last_of_run, out_padded_final);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver switches between open, light, heavy and periodic stalling.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      rx_style   = rx_style_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 64);
    end
    stall_left--;
    case (rx_style)
      RX_OPEN:     out_stall <= 1'b0;
      RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[2];
    endcase
  end

  // Sends one request in bursts with random gaps, and returns at its accepting edge.
  task automatic send_request(mode_t mode, logic [SYM_W-1:0] sym,
                              logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_symbol      <= sym;
    in_code_bits   <= code;
    in_code_length <= len;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic load_entry(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
                            logic [LEN_W-1:0] len);
    if (!written[sym]) begin
      written[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    send_request(MODE_LOAD, sym, code, len);
  endtask

  initial begin
    int               pick;
    logic [LEN_W-1:0] len;
    in_valid       <= 1'b0;
    in_mode        <= MODE_LOAD;
    in_symbol      <= '0;
    in_code_bits   <= '0;
    in_code_length <= '0;
    out_stall      <= 1'b0;
    rst_n          <= 1'b0;
    foreach (written[i]) written[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty flush, unused mode, clamped and stray-bit loads,
    // zero-length code, the longest codes on a nearly full accumulator.
    send_request(MODE_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    load_entry(8'h00, 32'h0000_0000, 6'd0);
    load_entry(8'hFF, 32'hFFFF_FFFF, 6'd32);
    load_entry(8'hA5, 32'hFFFF_FFFF, 6'd63);
    load_entry(8'h5A, 32'hDEAD_BEEF, 6'd3);
    load_entry(8'h01, 32'hFFFF_FFFF, 6'd1);
    load_entry(8'h02, 32'h0000_0055, 6'd7);
    load_entry(8'h03, 32'h0000_003C, 6'd8);
    load_entry(8'h80, 32'h1234_5678, 6'd33);
    send_request(MODE_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'h3F);
    send_request(MODE_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(MODE_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'hA5, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(MODE_NONE, 8'h00, 32'h0, 6'd0);
    send_request(MODE_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'h5A, 32'h0, 6'd0);
    send_request(MODE_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(MODE_FLUSH, 8'h00, 32'h0, 6'd0);

    // Random part: mostly encodes of loaded symbols, with table updates,
    // flushes and a little noise mixed in.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        if ($urandom_range(0, 9) < 7) len = LEN_W'($urandom_range(1, 10));
        else                          len = LEN_W'($urandom_range(0, 63));
        load_entry(SYM_W'($urandom_range(0, 255)), CODE_W'($urandom()), len);
      end else if (pick < 82) begin
        send_request(MODE_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     CODE_W'($urandom()), LEN_W'($urandom_range(0, 63)));
      end else if (pick < 94) begin
        send_request(MODE_FLUSH, SYM_W'($urandom_range(0, 255)), CODE_W'($urandom()),
                     LEN_W'($urandom_range(0, 63)));
      end else begin
        send_request(MODE_NONE, SYM_W'($urandom_range(0, 255)), CODE_W'($urandom()),
                     LEN_W'($urandom_range(0, 63)));
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    while (sb.expected_bytes.size() != 0) begin
      sb.report($sformatf("missing byte %h", sb.expected_bytes[0].data));
      void'(sb.expected_bytes.pop_front());
    end
    if (sb.errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
